>>> hdl/wpd_pkg.sv
`default_nettype none

package wpd_pkg;

    // Four-character codes as they read when assembled little-endian.
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    // Offset that moves a signed 16-bit sample to the unsigned range.
    localparam logic [15:0] SAMPLE_OFFSET = 16'h8000;

    // Timer period after reset.
    localparam logic [15:0] TIMER_PERIOD_RESET = 16'hFFFF;

    // Default depth of the command queue between the parser and the scaler.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Byte positions that close the file header and a chunk header.
    localparam logic [3:0] RIFF_LAST_BYTE  = 4'd11;
    localparam logic [3:0] CHUNK_LAST_BYTE = 4'd7;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_RIFF,
        PH_CHUNK,
        PH_SKIP,
        PH_DATA,
        PH_IDLE
    } phase_t;

    // Result kind.
    typedef enum logic [1:0] {
        KIND_DUTY,
        KIND_DATA,
        KIND_ERROR
    } kind_t;

    // Command passed from the parser to the scaler.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] sample;
        logic [31:0] size;
    } cmd_t;

endpackage

`default_nettype wire

>>> hdl/wav_stream_to_pwm_duty.sv
// A result passes through the command queue, the staging register and the output register.
// Throughput: one byte per cycle while in_stall is low; the parser, command queue and
// multiply stage all run concurrently, and each sample yields one duty result every two
// bytes. The QUEUE_DEPTH-entry command queue lets the parser keep taking bytes while
// results stall. Reset: rst_n is asynchronous, active low; it restarts header parsing,
// empties the queue and sets the timer period to 65535.
`default_nettype none

module wav_stream_to_pwm_duty #(
    parameter int QUEUE_DEPTH = wpd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [15:0]      duty,
    output logic [31:0]      data_size,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import wpd_pkg::*;

    logic [15:0] timer_period_reg;
    logic        push;
    cmd_t        push_cmd;
    cmd_t        head_cmd;
    logic        q_full;
    logic        q_empty;
    logic        pop;

    // Configuration transaction: the period register is always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_period_reg <= TIMER_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timer_period_reg <= cfg_data;
        end
    end

    // Byte parser.
    wpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    // Command queue between parser and scaler.
    wpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Duty scaler and output register.
    wpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .timer_period (timer_period_reg),
        .q_empty      (q_empty),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .duty         (duty),
        .data_size    (data_size)
    );

    // The queue can never report full and empty together.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_full && q_empty))
        else $error("command queue reports full and empty together");

    // A result that is not a duty sample carries a zero duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != KIND_DUTY)) |-> (duty == 16'd0))
        else $error("nonzero duty on a non-sample result");

    // A result that is not a data chunk report carries a zero size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != KIND_DATA)) |-> (data_size == 32'd0))
        else $error("nonzero data size on a non-chunk result");

    // A command popped from the queue reaches the staging register, so the queue never
    // pops while the output is stalled and the staging register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && out_valid && out_stall) |=> out_valid)
        else $error("output dropped while a command was in flight");

endmodule

`default_nettype wire

>>> hdl/wpd_front.sv
`default_nettype none

module wpd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    data_byte,
    input  wire logic          q_full,
    output logic               push,
    output wpd_pkg::cmd_t      cmd
);
    import wpd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] chunk_id_reg, chunk_id_next;
    logic [31:0] chunk_size_reg, chunk_size_next;
    logic [31:0] skip_reg, skip_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic        have_low_reg, have_low_next;

    logic        accept;
    logic [1:0]  lane;
    logic [31:0] size_last;
    logic [31:0] skip_dec;
    logic        riff_ok;
    logic        riff_end;
    logic        chunk_end;

    // A byte is taken whenever the queue has room for its possible command.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Shared decode of the current byte.
    assign lane      = count_reg[1:0];
    assign size_last = {data_byte, chunk_size_reg[23:0]};
    assign skip_dec  = skip_reg - {31'b0, |skip_reg};
    assign riff_ok   = (chunk_id_reg == ID_RIFF) && (size_last == ID_WAVE);
    assign riff_end  = (count_reg == RIFF_LAST_BYTE);
    assign chunk_end = (count_reg == CHUNK_LAST_BYTE);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_RIFF:
            begin
                if (accept && riff_end)
                begin
                    phase_next = riff_ok ? PH_CHUNK : PH_IDLE;
                end
            end
            PH_CHUNK:
            begin
                if (accept && chunk_end)
                begin
                    if (chunk_id_reg == ID_DATA)
                    begin
                        phase_next = PH_DATA;
                    end
                    else if (size_last != 32'd0)
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (accept && (skip_dec == 32'd0))
                begin
                    phase_next = PH_CHUNK;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Header assembly, skip count, sample pairing and command issue.
    always_comb
    begin
        count_next      = count_reg;
        chunk_id_next   = chunk_id_reg;
        chunk_size_next = chunk_size_reg;
        skip_next       = skip_reg;
        low_byte_next   = low_byte_reg;
        have_low_next   = have_low_reg;
        push            = 1'b0;
        cmd.kind        = KIND_DUTY;
        cmd.sample      = 16'd0;
        cmd.size        = 32'd0;
        if (accept)
        begin
            case (phase_reg)
                PH_RIFF:
                begin
                    if (count_reg < 4'd4)
                    begin
                        chunk_id_next[8*lane +: 8] = data_byte;
                    end
                    else if (count_reg >= 4'd8)
                    begin
                        chunk_size_next[8*lane +: 8] = data_byte;
                    end
                    count_next = count_reg + 4'd1;
                    if (riff_end)
                    begin
                        count_next      = 4'd0;
                        chunk_id_next   = 32'd0;
                        chunk_size_next = 32'd0;
                        if (!riff_ok)
                        begin
                            push     = 1'b1;
                            cmd.kind = KIND_ERROR;
                        end
                    end
                end
                PH_CHUNK:
                begin
                    if (count_reg < 4'd4)
                    begin
                        chunk_id_next[8*lane +: 8] = data_byte;
                    end
                    else
                    begin
                        chunk_size_next[8*lane +: 8] = data_byte;
                    end
                    count_next = count_reg + 4'd1;
                    if (chunk_end)
                    begin
                        count_next      = 4'd0;
                        chunk_id_next   = 32'd0;
                        chunk_size_next = 32'd0;
                        if (chunk_id_reg == ID_DATA)
                        begin
                            have_low_next = 1'b0;
                            push          = 1'b1;
                            cmd.kind      = KIND_DATA;
                            cmd.size      = size_last;
                        end
                        else if (size_last != 32'd0)
                        begin
                            skip_next = size_last;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                end
                PH_DATA:
                begin
                    if (!have_low_reg)
                    begin
                        low_byte_next = data_byte;
                        have_low_next = 1'b1;
                    end
                    else
                    begin
                        have_low_next = 1'b0;
                        push          = 1'b1;
                        cmd.kind      = KIND_DUTY;
                        cmd.sample    = {data_byte, low_byte_reg} + SAMPLE_OFFSET;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RIFF;
            count_reg      <= 4'd0;
            chunk_id_reg   <= 32'd0;
            chunk_size_reg <= 32'd0;
            skip_reg       <= 32'd0;
            low_byte_reg   <= 8'd0;
            have_low_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            chunk_id_reg   <= chunk_id_next;
            chunk_size_reg <= chunk_size_next;
            skip_reg       <= skip_next;
            low_byte_reg   <= low_byte_next;
            have_low_reg   <= have_low_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/wpd_queue.sv
`default_nettype none

module wpd_queue #(
    parameter int DEPTH = wpd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire wpd_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output wpd_pkg::cmd_t      head_cmd,
    output logic               full,
    output logic               empty
);
    import wpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/wpd_back.sv
`default_nettype none

module wpd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [15:0]   timer_period,
    input  wire logic          q_empty,
    input  wire wpd_pkg::cmd_t head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         kind,
    output logic [15:0]        duty,
    output logic [31:0]        data_size
);
    import wpd_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    cmd_t        s1_cmd_reg;
    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg;
    logic [15:0] out_duty_reg;
    logic [31:0] out_size_reg;

    logic        out_load;
    logic        s1_free;
    logic [31:0] product;

    // Handshake between the staging register and the output register.
    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_free  = !s1_valid_reg || out_load;
    assign pop      = s1_free && !q_empty;

    // One 16x16 multiply between the staging and output registers.
    assign product = 32'(s1_cmd_reg.sample) * 32'(timer_period);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers; unused fields of a result are driven to zero.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg <= head_cmd;
        end
        if (out_load)
        begin
            out_kind_reg <= s1_cmd_reg.kind;
            out_duty_reg <= (s1_cmd_reg.kind == KIND_DUTY) ? product[31:16] : 16'd0;
            out_size_reg <= (s1_cmd_reg.kind == KIND_DATA) ? s1_cmd_reg.size : 32'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign duty      = out_duty_reg;
    assign data_size = out_size_reg;

endmodule

`default_nettype wire

>>> tb/wav_result_checker.sv
`timescale 1ns / 1ps

module wav_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] duty,
    input  logic [31:0] data_size,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import wpd_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [15:0] duty;
        logic [31:0] size;
    } wav_result_t;

    // Results the parser owes, oldest first.
    wav_result_t parsed_results[$];

    // Mirror of the parser state and the timer period register.
    phase_t      parse_phase;
    logic [3:0]  hdr_count;
    logic [31:0] id_acc;
    logic [31:0] size_acc;
    logic [31:0] skip_left;
    logic [7:0]  low_byte;
    logic        have_low;
    logic [15:0] period;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 50)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    task automatic push_result(input kind_t k, input logic [15:0] d, input logic [31:0] s);
        wav_result_t r;
        r.kind = k;
        r.duty = d;
        r.size = s;
        parsed_results.push_back(r);
    endtask

    // Advance the parser mirror by one byte and record any result it causes.
    task automatic parse_wav_byte(input logic [7:0] b);
        int          n;
        logic [15:0] raw;
        logic [15:0] biased;
        logic [31:0] prod;
        n = int'(hdr_count);
        case (parse_phase)
            PH_RIFF:
            begin
                if (n < 4)
                begin
                    id_acc[8*n +: 8] = b;
                end
                else if (n >= 8)
                begin
                    size_acc[8*(n-8) +: 8] = b;
                end
                n++;
                hdr_count = 4'(n);
                if (n >= 12)
                begin
                    hdr_count = '0;
                    if (id_acc == ID_RIFF && size_acc == ID_WAVE)
                    begin
                        parse_phase = PH_CHUNK;
                    end
                    else
                    begin
                        parse_phase = PH_IDLE;
                        push_result(KIND_ERROR, 16'd0, 32'd0);
                    end
                    id_acc   = '0;
                    size_acc = '0;
                end
            end
            PH_CHUNK:
            begin
                if (n < 4)
                begin
                    id_acc[8*n +: 8] = b;
                end
                else
                begin
                    size_acc[8*(n-4) +: 8] = b;
                end
                n++;
                hdr_count = 4'(n);
                if (n >= 8)
                begin
                    hdr_count = '0;
                    if (id_acc == ID_DATA)
                    begin
                        parse_phase = PH_DATA;
                        have_low    = 1'b0;
                        push_result(KIND_DATA, 16'd0, size_acc);
                    end
                    else if (size_acc != 32'd0)
                    begin
                        skip_left   = size_acc;
                        parse_phase = PH_SKIP;
                    end
                    id_acc   = '0;
                    size_acc = '0;
                end
            end
            PH_SKIP:
            begin
                if (skip_left != 32'd0)
                begin
                    skip_left = skip_left - 32'd1;
                end
                if (skip_left == 32'd0)
                begin
                    parse_phase = PH_CHUNK;
                end
            end
            PH_DATA:
            begin
                if (!have_low)
                begin
                    low_byte = b;
                    have_low = 1'b1;
                end
                else
                begin
                    raw      = {b, low_byte};
                    biased   = raw + SAMPLE_OFFSET;
                    prod     = 32'(biased) * 32'(period);
                    have_low = 1'b0;
                    push_result(KIND_DUTY, prod[31:16], 32'd0);
                end
            end
            default:
            begin
                // Idle after a header error: bytes are dropped.
            end
        endcase
    endtask

    // Compare one accepted result against the oldest prediction.
    task automatic check_result();
        wav_result_t want;
        if (parsed_results.size() == 0)
        begin
            report_mismatch($sformatf("result kind %0d with none predicted", kind));
        end
        else
        begin
            want = parsed_results.pop_front();
            if (kind !== want.kind)
            begin
                report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
            end
            if (duty !== want.duty)
            begin
                report_mismatch($sformatf("duty got %0d want %0d", duty, want.duty));
            end
            if (data_size !== want.size)
            begin
                report_mismatch($sformatf("data_size got %0h want %0h", data_size, want.size));
            end
        end
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase = PH_RIFF;
            hdr_count   = '0;
            id_acc      = '0;
            size_acc    = '0;
            skip_left   = '0;
            low_byte    = '0;
            have_low    = 1'b0;
            period      = TIMER_PERIOD_RESET;
            parsed_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                period = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                parse_wav_byte(data_byte);
            end
            if (out_valid && !out_stall)
            begin
                check_result();
            end
        end
        pending = parsed_results.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import wpd_pkg::*;

    // Cycles without any transaction before the run is declared hung.
    localparam int HANG_LIMIT = 4000;
    localparam int TARGET_BYTES = 1300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = 8'd0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = 16'd0;
    logic        in_stall;
    logic        out_valid;
    logic [1:0]  kind;
    logic [15:0] duty;
    logic [31:0] data_size;
    logic        cfg_ready;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          stall_hold = 0;
    int          bytes_sent = 0;
    bit          burst = 1'b0;

    int          pos;
    int          n_bytes;
    logic [31:0] cid;
    logic [31:0] size_pick;
    logic [95:0] riff_hdr;

    wav_stream_to_pwm_duty u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .duty      (duty),
        .data_size (data_size),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    wav_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .duty       (duty),
        .data_size  (data_size),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hang detection: any transaction on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver back-pressure: a fresh stall length after every result.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            stall_hold = burst ? 0 : $urandom_range(0, 11);
        end
    end

    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            out_stall = 1'b1;
            stall_hold--;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    // Present one byte after a random gap and hold it until taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_word_le(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
        begin
            send_byte(w[8*i +: 8]);
        end
    endtask

    task automatic send_chunk(input logic [31:0] id, input logic [31:0] size);
        send_word_le(id);
        send_word_le(size);
        for (int i = 0; i < int'(size); i++)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_sample(input logic [15:0] s);
        send_byte(s[7:0]);
        send_byte(s[15:8]);
    endtask

    // Drain every owed result plus the pipeline depth before touching config.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_period(input logic [15:0] v);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        if ($urandom_range(0, 5) == 0)
        begin
            // Broken file header: one id byte is corrupted, later bytes are dropped.
            riff_hdr = {ID_WAVE, 32'($urandom), ID_RIFF};
            pos = $urandom_range(0, 7);
            if (pos >= 4)
            begin
                pos += 4;
            end
            riff_hdr[8*pos +: 8] = riff_hdr[8*pos +: 8] ^ 8'($urandom_range(1, 255));
            write_period(16'($urandom));
            for (int i = 0; i < 12; i++)
            begin
                send_byte(riff_hdr[8*i +: 8]);
            end
            while (bytes_sent < TARGET_BYTES)
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            // Valid header with the size field at both byte extremes.
            send_word_le(ID_RIFF);
            send_word_le(32'h00FF_00FF);
            send_word_le(ID_WAVE);

            // An empty chunk, then an odd-sized chunk whose id nearly matches.
            send_chunk(32'h5453_494C, 32'd0);
            send_chunk(ID_DATA ^ 32'h0100_0000, 32'd3);

            // A few other chunks with random ids and small payloads.
            repeat ($urandom_range(2, 6))
            begin
                cid = $urandom;
                if (cid == ID_DATA)
                begin
                    cid[0] = ~cid[0];
                end
                send_chunk(cid, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 24));
            end

            // The data chunk itself; its size is reported but bounds nothing.
            case ($urandom_range(0, 2))
                0: size_pick = 32'd0;
                1: size_pick = 32'hFFFF_FFFF;
                default: size_pick = $urandom;
            endcase
            send_word_le(ID_DATA);
            send_word_le(size_pick);

            // Sample extremes with the period still at its reset value.
            send_sample(16'h8000);
            send_sample(16'h7FFF);
            send_sample(16'h0000);
            send_sample(16'hFFFF);

            write_period(16'd0);
            send_sample(16'h7FFF);
            send_sample(16'h8000);
            write_period(16'd1);
            send_sample(16'h7FFF);
            write_period(16'hFFFF);
            send_sample(16'h7FFF);

            // Random sample streams under a series of periods.
            while (bytes_sent < TARGET_BYTES)
            begin
                case ($urandom_range(0, 5))
                    0: write_period(16'd0);
                    1: write_period(16'hFFFF);
                    2: write_period(16'd1);
                    default: write_period(16'($urandom));
                endcase
                burst = ($urandom_range(0, 3) == 0);
                n_bytes = $urandom_range(10, 150);
                for (int i = 0; i < n_bytes; i++)
                begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
            burst = 1'b0;
        end

        wait_idle();
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
